// ----- rtl/irunp_pkg.sv -----
// Shared types and constants for the packed 10-bit IR frame unpacker.
`default_nettype none
package irunp_pkg;

  localparam int GROUP_BYTES      = 5;
  localparam int PIXELS_PER_GROUP = 4;
  localparam int PIXEL_W          = 10;
  localparam int GRAY_W           = 8;
  localparam int BYTE_W           = 8;
  localparam int WORD_W           = GROUP_BYTES * BYTE_W;
  localparam int HELD_W           = (GROUP_BYTES - 1) * BYTE_W;
  localparam int HCNT_W           = 3;
  localparam int EXP_W            = 24;
  localparam int FB_W             = 24;
  localparam int COUNT_WIDTH_DFLT = 24;
  localparam int QUEUE_DEPTH      = 4;
  localparam int PIX_IDX_W        = 2;
  localparam int BYTES_GRAY16     = 2;
  localparam int BYTES_RGB24      = 3;

  localparam logic MODE_DATA = 1'b0;
  localparam logic MODE_EOF  = 1'b1;

  localparam logic FMT_GRAY16 = 1'b0;
  localparam logic FMT_RGB24  = 1'b1;

  localparam logic REG_OUTPUT_FORMAT = 1'b0;
  localparam logic REG_EXPECTED_SIZE = 1'b1;

  typedef struct packed {
    logic              is_status;
    logic [WORD_W-1:0] word;
    logic              fmt;
    logic              leftover;
    logic              size_err;
    logic [FB_W-1:0]   frame_bytes;
  } entry_t;

  typedef struct packed {
    logic               is_status;
    logic [PIXEL_W-1:0] pixel;
    logic [GRAY_W-1:0]  gray;
    logic               last;
    logic               leftover;
    logic               size_err;
    logic [FB_W-1:0]    frame_bytes;
  } result_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qctl_t;

endpackage
`default_nettype wire

// ----- rtl/irunp_front.sv -----
// Front end: byte gathering, output byte count, frame status and configuration registers.
`default_nettype none
module irunp_front
  import irunp_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DFLT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [EXP_W-1:0]  cfg_wdata,
  input  wire logic              in_push,
  input  wire logic              in_mode,
  input  wire logic [BYTE_W-1:0] in_data_byte,
  input  wire logic              q_full,
  output logic                   in_full,
  output logic                   q_push,
  output entry_t                 q_entry
);

  localparam int CMP_W = (COUNT_WIDTH > EXP_W) ? COUNT_WIDTH : EXP_W;

  logic                   fmt_r;
  logic [EXP_W-1:0]       exp_r;
  logic [HELD_W-1:0]      held_r, held_nxt;
  logic [HCNT_W-1:0]      hcnt_r, hcnt_nxt;
  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [COUNT_WIDTH:0]   sum;
  logic [CMP_W-1:0]       cnt_ext;
  logic [CMP_W-1:0]       exp_ext;
  logic                   accept;
  logic                   group_done;

  assign in_full    = q_full;
  assign accept     = in_push && !q_full;
  assign group_done = (hcnt_r == HCNT_W'(GROUP_BYTES - 1));
  assign q_push     = accept && ((in_mode == MODE_EOF) || group_done);

  assign cnt_ext = CMP_W'(cnt_r);
  assign exp_ext = CMP_W'(exp_r);

  always_comb begin
    if (fmt_r == FMT_RGB24) begin
      sum = {1'b0, cnt_r} + (COUNT_WIDTH+1)'(PIXELS_PER_GROUP * BYTES_RGB24);
    end else begin
      sum = {1'b0, cnt_r} + (COUNT_WIDTH+1)'(PIXELS_PER_GROUP * BYTES_GRAY16);
    end
  end

  always_comb begin
    q_entry.is_status   = (in_mode == MODE_EOF);
    q_entry.word        = {held_r, in_data_byte};
    q_entry.fmt         = fmt_r;
    q_entry.leftover    = (hcnt_r != '0);
    q_entry.size_err    = (cnt_ext != exp_ext);
    q_entry.frame_bytes = cnt_ext[FB_W-1:0];
  end

  always_comb begin
    held_nxt = held_r;
    hcnt_nxt = hcnt_r;
    cnt_nxt  = cnt_r;
    if (accept) begin
      if (in_mode == MODE_EOF) begin
        held_nxt = '0;
        hcnt_nxt = '0;
        cnt_nxt  = '0;
      end else if (group_done) begin
        held_nxt = '0;
        hcnt_nxt = '0;
        cnt_nxt  = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
      end else begin
        held_nxt = {held_r[HELD_W-BYTE_W-1:0], in_data_byte};
        hcnt_nxt = hcnt_r + HCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fmt_r  <= FMT_GRAY16;
      exp_r  <= '0;
      held_r <= '0;
      hcnt_r <= '0;
      cnt_r  <= '0;
    end else begin
      held_r <= held_nxt;
      hcnt_r <= hcnt_nxt;
      cnt_r  <= cnt_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_OUTPUT_FORMAT: fmt_r <= cfg_wdata[0];
          REG_EXPECTED_SIZE: exp_r <= cfg_wdata;
          default:           exp_r <= exp_r;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

// ----- rtl/irunp_queue.sv -----
// Short entry queue between the front end and the pixel emitter.
`default_nettype none
module irunp_queue
  import irunp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t wr_entry,
  input  wire logic   pop,
  output entry_t      rd_entry,
  output logic        full,
  output logic        empty
);

  qctl_t stat;

  irunp_fifo #(
    .DEPTH (DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .wr_entry (wr_entry),
    .pop      (pop),
    .rd_entry (rd_entry),
    .status   (stat)
  );

  assign full  = stat.full;
  assign empty = stat.empty;

endmodule
`default_nettype wire

// ----- rtl/irunp_back.sv -----
// Back end: splits queued groups into pixel results and holds the output register.
`default_nettype none
module irunp_back
  import irunp_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_empty,
  input  wire entry_t q_entry,
  input  wire logic   out_pop,
  output logic        q_pop,
  output logic        out_empty,
  output result_t     out_res
);

  logic                 vld_r, vld_nxt;
  logic [PIX_IDX_W-1:0] idx_r, idx_nxt;
  result_t              res_r;
  result_t              res_nxt;
  logic                 adv;
  logic                 load;
  logic [PIXEL_W-1:0]   pix;
  logic                 last_pix;

  assign adv       = !vld_r || out_pop;
  assign load      = adv && !q_empty;
  assign last_pix  = (idx_r == PIX_IDX_W'(PIXELS_PER_GROUP - 1));
  assign q_pop     = load && (q_entry.is_status || last_pix);
  assign out_empty = !vld_r;
  assign out_res   = res_r;

  always_comb begin
    case (idx_r)
      2'd0:    pix = q_entry.word[WORD_W-1 -: PIXEL_W];
      2'd1:    pix = q_entry.word[WORD_W-1-PIXEL_W -: PIXEL_W];
      2'd2:    pix = q_entry.word[WORD_W-1-2*PIXEL_W -: PIXEL_W];
      default: pix = q_entry.word[PIXEL_W-1:0];
    endcase
  end

  always_comb begin
    res_nxt.is_status = q_entry.is_status;
    if (q_entry.is_status) begin
      res_nxt.pixel       = '0;
      res_nxt.gray        = '0;
      res_nxt.last        = 1'b1;
      res_nxt.leftover    = q_entry.leftover;
      res_nxt.size_err    = q_entry.size_err;
      res_nxt.frame_bytes = q_entry.frame_bytes;
    end else begin
      res_nxt.pixel       = pix;
      res_nxt.gray        = (q_entry.fmt == FMT_RGB24) ? pix[PIXEL_W-1 -: GRAY_W] : '0;
      res_nxt.last        = last_pix;
      res_nxt.leftover    = 1'b0;
      res_nxt.size_err    = 1'b0;
      res_nxt.frame_bytes = '0;
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    idx_nxt = idx_r;
    if (adv) begin
      vld_nxt = !q_empty;
    end
    if (load) begin
      idx_nxt = q_pop ? '0 : idx_r + PIX_IDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
      idx_r <= '0;
    end else begin
      vld_r <= vld_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/irunp_fifo.sv -----
// Small first-in first-out store of front-end entries.
`default_nettype none
module irunp_fifo
  import irunp_pkg::*;
#(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push,
  input  wire entry_t wr_entry,
  input  wire logic   pop,
  output entry_t      rd_entry,
  output qctl_t       status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  entry_t             mem [DEPTH];
  logic [PTR_W-1:0]   wp_r, wp_nxt;
  logic [PTR_W-1:0]   rp_r, rp_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               do_push;
  logic               do_pop;

  assign status.full  = (cnt_r == CNT_W'(DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign rd_entry     = mem[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == PTR_W'(DEPTH - 1)) ? '0 : wp_r + PTR_W'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == PTR_W'(DEPTH - 1)) ? '0 : rp_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wp_r] <= wr_entry;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/packed_10bit_ir_frame_unpacker_unit.sv -----
// Top level of the packed 10-bit IR frame unpacker.
//
// Input queue port: present a byte (in_mode low) or an end-of-frame marker
// (in_mode high) with in_push; the transfer happens on a clock edge with
// in_push high and in_full low. One transfer per cycle is sustained while in_full stays low.
// Every fifth data byte completes a 40-bit group that yields four 10-bit
// pixels, most significant bits first; the fourth carries out_last. An
// end-of-frame marker yields one status result with out_last set, then
// clears the held bytes and the output byte count.
// Result queue port: the oldest result is on the out_ ports while out_empty
// is low; pop it with out_pop. The first result passes through the group
// queue and then the output register. Pixels drain at one per cycle while
// out_pop stays high, so four pixels per five input bytes keep up with input.
// A stalled receiver fills the output register and then the four-entry
// group queue; in_full then rises until results are popped.
// Reset (rst_n low, synchronous) empties both queues, clears the held
// bytes and count, and sets the format to gray16 and expected size to 0.
// Write cfg_ registers only while the block is idle.
`default_nettype none
module packed_10bit_ir_frame_unpacker_unit
  import irunp_pkg::*;
#(
  parameter int COUNT_WIDTH = COUNT_WIDTH_DFLT
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [EXP_W-1:0]  cfg_wdata,
  input  wire logic              in_push,
  input  wire logic              in_mode,
  input  wire logic [BYTE_W-1:0] in_data_byte,
  output logic                   in_full,
  input  wire logic              out_pop,
  output logic                   out_empty,
  output logic                   out_is_status,
  output logic [PIXEL_W-1:0]     out_pixel_value,
  output logic [GRAY_W-1:0]      out_red,
  output logic [GRAY_W-1:0]      out_green,
  output logic [GRAY_W-1:0]      out_blue,
  output logic                   out_last,
  output logic                   out_leftover_error,
  output logic                   out_size_error,
  output logic [FB_W-1:0]        out_frame_bytes
);

  entry_t  f_entry;
  entry_t  q_head;
  logic    q_full;
  logic    q_empty;
  logic    f_push;
  logic    b_pop;
  result_t res;

  irunp_front #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_push      (in_push),
    .in_mode      (in_mode),
    .in_data_byte (in_data_byte),
    .q_full       (q_full),
    .in_full      (in_full),
    .q_push       (f_push),
    .q_entry      (f_entry)
  );

  irunp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (f_push),
    .wr_entry (f_entry),
    .pop      (b_pop),
    .rd_entry (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  irunp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .q_entry   (q_head),
    .out_pop   (out_pop),
    .q_pop     (b_pop),
    .out_empty (out_empty),
    .out_res   (res)
  );

  assign out_is_status      = res.is_status;
  assign out_pixel_value    = res.pixel;
  assign out_red            = res.gray;
  assign out_green          = res.gray;
  assign out_blue           = res.gray;
  assign out_last           = res.last;
  assign out_leftover_error = res.leftover;
  assign out_size_error     = res.size_err;
  assign out_frame_bytes    = res.frame_bytes;

endmodule
`default_nettype wire
